FILE: src/sls_pkg.sv
package sls_pkg;

    // Width of a level value.
    localparam int LEVEL_BITS = 20;

    // Fixed field widths.
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 2;
    localparam int LIMIT_BITS     = 8;
    localparam int SHARE_BITS     = 16;
    localparam int ACTION_BITS    = 2;
    localparam int RESULT_BITS    = 2;

    // Growth arithmetic widths (Q16 fixed point).
    localparam int H_BITS      = SHARE_BITS + 1;
    localparam int HH_BITS     = 2 * H_BITS - 1;
    localparam int H3_BITS     = HH_BITS + H_BITS - 1;
    localparam int FACTOR_BITS = H_BITS + 1;
    localparam int PROD_BITS   = LEVEL_BITS + FACTOR_BITS;

    typedef logic [LEVEL_BITS-1:0] level_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LEVEL       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_LEVEL     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BISECTION_LIMIT = 2'd2;

    // Input operation codes.
    localparam logic OP_START  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Trial outcome codes.
    localparam logic [RESULT_BITS-1:0] TR_PASSED    = 2'd0;
    localparam logic [RESULT_BITS-1:0] TR_FAILED    = 2'd1;
    localparam logic [RESULT_BITS-1:0] TR_SRC_LIMIT = 2'd2;
    localparam logic [RESULT_BITS-1:0] TR_CANCELLED = 2'd3;

    // Result action codes.
    localparam logic [ACTION_BITS-1:0] ACT_TRY      = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_FINISHED = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_IGNORED  = 2'd2;

    // Search phase.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_GROW   = 2'd1,
        PH_HALVE  = 2'd2,
        PH_REFINE = 2'd3
    } phase_t;

    // Controller sequence.
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_MUL1,
        CS_MUL2,
        CS_MUL3,
        CS_COMMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mul1;
        logic mul2;
        logic mul3;
        logic commit;
    } dp_cmd_t;

endpackage

FILE: src/sls_ctrl.sv
module sls_ctrl
    import sls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_beat;
    logic        out_free;

    assign in_stall  = (state_reg != CS_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    // The output register can take a result when empty or emptied this cycle.
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = CS_MUL1;
                end
            end
            CS_MUL1:   state_next = CS_MUL2;
            CS_MUL2:   state_next = CS_MUL3;
            CS_MUL3:   state_next = CS_COMMIT;
            CS_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:   state_next = CS_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            CS_IDLE:   cmd.load_in = in_beat;
            CS_MUL1:   cmd.mul1    = 1'b1;
            CS_MUL2:   cmd.mul2    = 1'b1;
            CS_MUL3:   cmd.mul3    = 1'b1;
            CS_COMMIT: cmd.commit  = out_free;
            default:   cmd         = '0;
        endcase
    end

    // Output beat tracking.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/sls_dp.sv
module sls_dp
    import sls_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      op,
    input  logic [RESULT_BITS-1:0]    trial_result,
    input  logic [SHARE_BITS-1:0]     backlog_use,
    output logic [ACTION_BITS-1:0]    action,
    output level_t                    level,
    output logic                      reached_max,
    output logic                      inconclusive,
    output logic                      cancelled
);

    // Configuration registers.
    level_t                  max_level_reg;
    level_t                  start_level_reg;
    logic [LIMIT_BITS-1:0]   limit_reg;

    // Latched input beat.
    logic                    op_reg;
    logic [RESULT_BITS-1:0]  trial_reg;
    logic [SHARE_BITS-1:0]   share_reg;

    // Growth arithmetic pipeline.
    logic [H_BITS-1:0]       h_reg;
    logic [HH_BITS-1:0]      hh_reg;
    logic [H3_BITS-1:0]      h3_reg;
    logic [PROD_BITS-1:0]    prod_reg;

    // Search state.
    phase_t                  phase_reg, phase_next;
    level_t                  cur_reg, cur_next;
    level_t                  bp_reg, bp_next;
    level_t                  lb_reg, lb_next;
    level_t                  lrf_reg, lrf_next;
    logic [LIMIT_BITS-1:0]   bd_reg, bd_next;
    logic                    rm_reg, rm_next;
    logic                    inc_reg, inc_next;
    logic                    can_reg, can_next;

    // Result payload.
    logic [ACTION_BITS-1:0]  res_action;
    level_t                  res_level;
    logic                    res_rm;
    logic                    res_inc;
    logic                    res_can;
    logic [ACTION_BITS-1:0]  action_reg;
    level_t                  level_reg;
    logic                    rm_out_reg;
    logic                    inc_out_reg;
    logic                    can_out_reg;

    // Combinational helpers.
    logic [H_BITS-1:0]       two_share;
    logic [H_BITS-1:0]       h_val;
    logic [H3_BITS-1:0]      h3_round;
    logic [FACTOR_BITS-1:0]  factor;
    logic [PROD_BITS-1:0]    prod_round;
    logic [PROD_BITS-17:0]   grow_raw;
    logic [LEVEL_BITS:0]     level_inc;
    logic [PROD_BITS-17:0]   grow_floor;
    level_t                  grow_level;
    level_t                  cap;
    level_t                  start_clamp;
    logic                    passed;
    level_t                  upd_bp;
    level_t                  upd_lb;
    level_t                  upd_lrf;
    logic                    upd_inc;
    logic                    grow_more;
    logic                    cap_pass;
    logic [LEVEL_BITS:0]     mid_sum;
    level_t                  mid;
    logic                    halve_go;
    logic                    refine_go;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg   <= level_t'(20'hFFFFF);
            start_level_reg <= level_t'(1);
            limit_reg       <= LIMIT_BITS'(8);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_LEVEL)
            begin
                max_level_reg <= level_t'(cfg_data);
            end
            if (cfg_index == REG_START_LEVEL)
            begin
                start_level_reg <= level_t'(cfg_data);
            end
            if (cfg_index == REG_BISECTION_LIMIT)
            begin
                limit_reg <= cfg_data[LIMIT_BITS-1:0];
            end
        end
    end

    // Input beat capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= op;
            trial_reg <= trial_result;
            share_reg <= backlog_use;
        end
    end

    // Headroom h = 1 - 2*share in Q16, floored at zero.
    assign two_share = {share_reg, 1'b0};
    assign h_val     = two_share[H_BITS-1] ? '0 : (H_BITS'(65536) - two_share);

    // Cube rounded to Q16, then the growth factor 1 + h^3.
    assign h3_round = h3_reg + H3_BITS'(64'h8000_0000);
    assign factor   = FACTOR_BITS'(65536) + FACTOR_BITS'(h3_round[H3_BITS-1:32]);

    // Multiplier pipeline, one product per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            h_reg  <= h_val;
            hh_reg <= HH_BITS'(h_val * h_val);
        end
        if (cmd.mul2)
        begin
            h3_reg <= H3_BITS'(hh_reg * h_reg);
        end
        if (cmd.mul3)
        begin
            prod_reg <= PROD_BITS'(cur_reg * factor);
        end
    end

    // Rounded growth level, at least level + 1, at most the cap.
    assign cap        = (max_level_reg == '0) ? level_t'(1) : max_level_reg;
    assign prod_round = prod_reg + PROD_BITS'(32768);
    assign grow_raw   = prod_round[PROD_BITS-1:16];
    assign level_inc  = {1'b0, cur_reg} + (LEVEL_BITS+1)'(1);
    assign grow_floor = (grow_raw < (PROD_BITS-16)'(level_inc))
                        ? (PROD_BITS-16)'(level_inc) : grow_raw;
    assign grow_level = (grow_floor > (PROD_BITS-16)'(cap))
                        ? cap : grow_floor[LEVEL_BITS-1:0];

    // Start level clamped into one to the cap.
    always_comb
    begin
        start_clamp = start_level_reg;
        if (start_clamp == '0)
        begin
            start_clamp = level_t'(1);
        end
        if (start_clamp > cap)
        begin
            start_clamp = cap;
        end
    end

    // Bound updates from a trial report.
    assign passed  = (trial_reg == TR_PASSED);
    assign upd_bp  = (passed && (cur_reg > bp_reg)) ? cur_reg : bp_reg;
    assign upd_lb  = (!passed && ((lb_reg == '0) || (cur_reg < lb_reg))) ? cur_reg : lb_reg;
    assign upd_lrf = ((trial_reg == TR_FAILED) && ((lrf_reg == '0) || (cur_reg < lrf_reg)))
                     ? cur_reg : lrf_reg;
    assign upd_inc = (upd_lb != '0) && (upd_lrf != upd_lb);

    // Phase decisions after a report.
    assign grow_more = (phase_reg == PH_GROW) && passed && (cur_reg < cap);
    assign cap_pass  = (phase_reg == PH_GROW) && passed && (cur_reg >= cap);
    assign mid_sum   = {1'b0, upd_bp} + {1'b0, upd_lb};
    assign mid       = mid_sum[LEVEL_BITS:1];
    assign halve_go  = (upd_bp == '0) && (upd_lb > level_t'(1));
    assign refine_go = (upd_lb != '0) && (bd_reg < limit_reg)
                       && (mid > upd_bp) && (mid < upd_lb);

    // Next search state and result.
    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        bp_next    = bp_reg;
        lb_next    = lb_reg;
        lrf_next   = lrf_reg;
        bd_next    = bd_reg;
        rm_next    = rm_reg;
        inc_next   = inc_reg;
        can_next   = can_reg;
        res_action = ACT_IGNORED;
        res_level  = '0;
        res_rm     = 1'b0;
        res_inc    = 1'b0;
        res_can    = 1'b0;
        priority if (op_reg == OP_START)
        begin
            bp_next    = '0;
            lb_next    = '0;
            lrf_next   = '0;
            bd_next    = '0;
            rm_next    = 1'b0;
            inc_next   = 1'b0;
            can_next   = 1'b0;
            phase_next = PH_GROW;
            cur_next   = start_clamp;
            res_action = ACT_TRY;
            res_level  = start_clamp;
        end
        else if (phase_reg == PH_IDLE)
        begin
            res_action = ACT_IGNORED;
        end
        else if (trial_reg == TR_CANCELLED)
        begin
            can_next   = 1'b1;
            phase_next = PH_IDLE;
            res_action = ACT_FINISHED;
            res_level  = bp_reg;
            res_rm     = rm_reg;
            res_inc    = inc_reg;
            res_can    = 1'b1;
        end
        else
        begin
            bp_next  = upd_bp;
            lb_next  = upd_lb;
            lrf_next = upd_lrf;
            inc_next = upd_inc;
            if (grow_more)
            begin
                phase_next = PH_GROW;
                cur_next   = grow_level;
                res_action = ACT_TRY;
                res_level  = grow_level;
            end
            else
            begin
                rm_next = rm_reg | cap_pass;
                priority if (halve_go)
                begin
                    phase_next = PH_HALVE;
                    cur_next   = upd_lb >> 1;
                    res_action = ACT_TRY;
                    res_level  = upd_lb >> 1;
                end
                else if (refine_go)
                begin
                    bd_next    = bd_reg + LIMIT_BITS'(1);
                    phase_next = PH_REFINE;
                    cur_next   = mid;
                    res_action = ACT_TRY;
                    res_level  = mid;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    res_action = ACT_FINISHED;
                    res_level  = upd_bp;
                    res_rm     = rm_next;
                    res_inc    = upd_inc;
                    res_can    = can_reg;
                end
            end
        end
    end

    // Search state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cur_reg   <= '0;
            bp_reg    <= '0;
            lb_reg    <= '0;
            lrf_reg   <= '0;
            bd_reg    <= '0;
            rm_reg    <= 1'b0;
            inc_reg   <= 1'b0;
            can_reg   <= 1'b0;
        end
        else if (cmd.commit)
        begin
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            bp_reg    <= bp_next;
            lb_reg    <= lb_next;
            lrf_reg   <= lrf_next;
            bd_reg    <= bd_next;
            rm_reg    <= rm_next;
            inc_reg   <= inc_next;
            can_reg   <= can_next;
        end
    end

    // Output register, held while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            action_reg  <= res_action;
            level_reg   <= res_level;
            rm_out_reg  <= res_rm;
            inc_out_reg <= res_inc;
            can_out_reg <= res_can;
        end
    end

    assign action       = action_reg;
    assign level        = level_reg;
    assign reached_max  = rm_out_reg;
    assign inconclusive = inc_out_reg;
    assign cancelled    = can_out_reg;

endmodule

FILE: src/sustainable_level_search_unit.sv
// Highest sustainable level search controller.
// Input channel (in_valid / in_stall): one beat is either a start command
// (op 0), which clears the search and asks for the start level, or the report
// of the trial last requested (op 1) with its outcome and backlog share.
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat: try a level, search finished with the best passing level and flags,
// or report ignored while no search runs.
// An input beat, once taken, passes the registered multiply chain for the growth
// cube and scaling (states MUL1, MUL2, MUL3), then the decision state (COMMIT)
// that loads the output register. One item is in work at a time and the
// controller takes the next beat only once it is back in idle, so no new beat
// is taken before the last one has passed the decision state.
// The output register frees the input side: a new beat is taken while an
// earlier result still waits. A stalled result holds, and the decision of the
// next item waits until the output register is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant for idle periods.
// Reset sets the configuration registers to their defaults and the search to idle.
module sustainable_level_search_unit
    import sls_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      op,
    input  logic [RESULT_BITS-1:0]    trial_result,
    input  logic [SHARE_BITS-1:0]     backlog_use,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [ACTION_BITS-1:0]    action,
    output level_t                    level,
    output logic                      reached_max,
    output logic                      inconclusive,
    output logic                      cancelled
);

    dp_cmd_t cmd;

    // Sequencing and handshakes.
    sls_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Arithmetic, search state and result register.
    sls_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .trial_result (trial_result),
        .backlog_use  (backlog_use),
        .action       (action),
        .level        (level),
        .reached_max  (reached_max),
        .inconclusive (inconclusive),
        .cancelled    (cancelled)
    );

endmodule
